/* sv/thlam_pkg.sv */
// Shared types, constants and register codes for the thermal and light alarm monitor.
package thlam_pkg;

    // Field and bus widths.
    localparam int TIME_BITS  = 32;
    localparam int ADC_W      = 10;
    localparam int TEMP_W     = 20;
    localparam int DUTY_W     = 8;
    localparam int DEB_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;

    // Ramp divider sizing: numerator is (t - a) * 225, quotient stays below 225.
    localparam int DIFF_W    = 20;
    localparam int NUM_W     = 28;
    localparam int QUOT_W    = 8;
    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Temperature conversion: t = raw * 500 - 51200 in Q10 Celsius.
    localparam int TEMP_SCALE  = 500;
    localparam int TEMP_OFFSET = 51200;

    // Red ramp constants.
    localparam int RAMP_MIN  = 30;
    localparam int RAMP_MAX  = 255;
    localparam int RAMP_SPAN = 225;

    // Register reset values.
    localparam int RST_TEMP_NORMAL    = 25600;
    localparam int RST_TEMP_ATTENTION = 30720;
    localparam int RST_TEMP_CRITICAL  = 35840;
    localparam int RST_LDR_DARK       = 300;
    localparam int RST_LDR_CLEAR      = 700;
    localparam int RST_DEBOUNCE       = 50;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_NORMAL    = 3'd0,
        REG_TEMP_ATTENTION = 3'd1,
        REG_TEMP_CRITICAL  = 3'd2,
        REG_LDR_DARK       = 3'd3,
        REG_LDR_CLEAR      = 3'd4,
        REG_LDR_PULLUP     = 3'd5,
        REG_DEBOUNCE       = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TCLS_NORMAL    = 2'd0,
        TCLS_ATTENTION = 2'd1,
        TCLS_APPROACH  = 2'd2,
        TCLS_CRITICAL  = 2'd3
    } temp_class_t;

    typedef enum logic [1:0] {
        LCLS_DARK     = 2'd0,
        LCLS_MODERATE = 2'd1,
        LCLS_CLEAR    = 2'd2
    } light_class_t;

    // Command and status between the sequencer and the ramp divider.
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DIFF_W-1:0] den;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

endpackage

/* sv/thermal_light_alarm_monitor.sv */
// Top level of the thermal and light alarm monitor: sequencer, classes, debounce and ports.
//
// Usage: each input transaction on the s_ channel carries one sample (temperature
// count, light count, button level, millisecond timestamp) and yields exactly one
// result transaction on the m_ channel with the Q10 temperature, the temperature
// and light classes, the LED controls, the red PWM duty and the alarm state.
// The block takes one sample at a time: s_tready is high only while the
// sequencer is idle. Each sample passes through the temperature, class and output
// states, and in the approach band below the critical limit also through the divide
// state, where the red duty comes from an 8-step restoring divider (one quotient
// bit per cycle) and its quotient is captured into the duty register. A new sample
// is not taken before the result of the last one is loaded into the output register.
// The result sits in an output register; s_tready rises again once the result
// is loaded, so a new sample is taken while the old result waits. If the
// receiver stalls with a result still held, the next finished result waits in
// the sequencer until the output register frees.
// Configuration writes on the cfg_ channel are always accepted
// and are meant for idle periods only; unknown indexes are ignored.
// Reset (aresetn low, synchronous) restores the default limits, releases the
// button debouncer, enables sound and empties the output register.
module thermal_light_alarm_monitor (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Sample channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: temp_sample[9:0], light_sample[19:10], now_ms[51:20], zeros[55:52]
    input  logic [thlam_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser: button_level[0]
    input  logic [0:0]                          s_tuser,
    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: temperature_q10[19:0], temp_class[21:20], light_class[23:22],
    //        green_on[24], yellow_on[25], red_duty[33:26], buzzer_on[34],
    //        alarm_enabled[35], mute_toggled[36], zeros[39:37]
    output logic [thlam_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [thlam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [thlam_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import thlam_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEMP,
        ST_CLASS,
        ST_DIV,
        ST_OUT
    } state_t;

    // Configuration registers.
    logic signed [TEMP_W-1:0] normal_lim_reg;
    logic signed [TEMP_W-1:0] atten_lim_reg;
    logic signed [TEMP_W-1:0] crit_lim_reg;
    logic [ADC_W-1:0]         dark_lim_reg;
    logic [ADC_W-1:0]         clear_lim_reg;
    logic                     pullup_reg;
    logic [DEB_W-1:0]         debounce_reg;

    // Sequencer and debounce state.
    state_t                   state_reg, state_next;
    logic                     raw_last_reg, raw_last_next;
    logic                     stable_reg, stable_next;
    logic [TIME_BITS-1:0]     last_change_reg, last_change_next;
    logic                     sound_en_reg, sound_en_next;
    logic                     toggled_reg, toggled_next;

    // Per-sample working registers.
    logic [ADC_W-1:0]         temp_raw_reg, temp_raw_next;
    logic [ADC_W-1:0]         light_reg, light_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    temp_class_t              tcls_reg, tcls_next;
    light_class_t             lcls_reg, lcls_next;
    logic [DUTY_W-1:0]        duty_reg, duty_next;

    // Output register.
    logic                     m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]     m_data_reg, m_data_next;

    // Divider link.
    div_cmd_t                 div_cmd;
    div_stat_t                div_stat;

    // Combinational helpers.
    logic                     in_level;
    logic [TIME_BITS-1:0]     in_now;
    logic                     level_changed;
    logic [TIME_BITS-1:0]     elapsed;
    logic                     settled;
    logic signed [TEMP_W:0]   diff_ta;
    logic signed [TEMP_W:0]   diff_ca;
    temp_class_t              tcls_calc;
    logic                     dark, clear;
    logic                     alarm;

    thlam_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .stat    (div_stat)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Input field extraction and debounce timing.
    assign in_level      = s_tuser[0];
    assign in_now        = s_tdata[2*ADC_W +: TIME_BITS];
    assign level_changed = (in_level != raw_last_reg);
    assign elapsed       = level_changed ? '0 : (in_now - last_change_reg);
    assign settled       = elapsed > TIME_BITS'(debounce_reg);

    // Ramp operands, taken one bit wider so the difference cannot overflow.
    assign diff_ta = {temp_reg[TEMP_W-1], temp_reg} - {atten_lim_reg[TEMP_W-1], atten_lim_reg};
    assign diff_ca = {crit_lim_reg[TEMP_W-1], crit_lim_reg} - {atten_lim_reg[TEMP_W-1], atten_lim_reg};

    // Temperature classes are tested in order: normal, attention, approach.
    always_comb begin
        if (temp_reg <= normal_lim_reg) begin
            tcls_calc = TCLS_NORMAL;
        end else if (temp_reg <= atten_lim_reg) begin
            tcls_calc = TCLS_ATTENTION;
        end else if (temp_reg <= crit_lim_reg) begin
            tcls_calc = TCLS_APPROACH;
        end else begin
            tcls_calc = TCLS_CRITICAL;
        end
    end

    // Light bands; polarity follows the pull-up mode bit.
    always_comb begin
        if (pullup_reg) begin
            dark  = light_reg > dark_lim_reg;
            clear = light_reg < clear_lim_reg;
        end else begin
            dark  = light_reg < dark_lim_reg;
            clear = light_reg > clear_lim_reg;
        end
    end

    assign alarm = (tcls_reg == TCLS_CRITICAL) || (lcls_reg == LCLS_DARK);

    // Divider command is issued from the classification step.
    always_comb begin
        div_cmd.start = (state_reg == ST_CLASS) && (tcls_calc == TCLS_APPROACH)
                        && (temp_reg != crit_lim_reg);
        div_cmd.num   = NUM_W'(diff_ta[DIFF_W-1:0]) * NUM_W'(RAMP_SPAN);
        div_cmd.den   = diff_ca[DIFF_W-1:0];
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next       = state_reg;
        raw_last_next    = raw_last_reg;
        stable_next      = stable_reg;
        last_change_next = last_change_reg;
        sound_en_next    = sound_en_reg;
        toggled_next     = toggled_reg;
        temp_raw_next    = temp_raw_reg;
        light_next       = light_reg;
        temp_next        = temp_reg;
        tcls_next        = tcls_reg;
        lcls_next        = lcls_reg;
        duty_next        = duty_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                // Accept a sample and run the button debouncer on it.
                if (s_tvalid) begin
                    temp_raw_next = s_tdata[0 +: ADC_W];
                    light_next    = s_tdata[ADC_W +: ADC_W];
                    toggled_next  = 1'b0;
                    if (level_changed) begin
                        last_change_next = in_now;
                        raw_last_next    = in_level;
                    end
                    if (settled && (in_level != stable_reg)) begin
                        stable_next = in_level;
                        if (!in_level) begin
                            toggled_next  = 1'b1;
                            sound_en_next = !sound_en_reg;
                        end
                    end
                    state_next = ST_TEMP;
                end
            end
            ST_TEMP: begin
                // Exact Q10 conversion; the result always fits in 20 bits.
                temp_next  = $signed(TEMP_W'(temp_raw_reg) * TEMP_W'(TEMP_SCALE)
                                     - TEMP_W'(TEMP_OFFSET));
                state_next = ST_CLASS;
            end
            ST_CLASS: begin
                tcls_next = tcls_calc;
                if (dark) begin
                    lcls_next = LCLS_DARK;
                end else if (clear) begin
                    lcls_next = LCLS_CLEAR;
                end else begin
                    lcls_next = LCLS_MODERATE;
                end
                if (div_cmd.start) begin
                    state_next = ST_DIV;
                end else begin
                    // Full duty when critical or sitting exactly on the critical limit.
                    if (tcls_calc == TCLS_CRITICAL || tcls_calc == TCLS_APPROACH) begin
                        duty_next = DUTY_W'(RAMP_MAX);
                    end else begin
                        duty_next = '0;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                // Quotient stays below the span, so no clamping is needed.
                if (div_stat.done) begin
                    duty_next  = DUTY_W'(RAMP_MIN) + div_stat.quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Load the result once the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({
                        toggled_reg,
                        sound_en_reg,
                        alarm && sound_en_reg,
                        duty_reg,
                        (tcls_reg == TCLS_ATTENTION),
                        (tcls_reg == TCLS_NORMAL),
                        lcls_reg,
                        tcls_reg,
                        temp_reg
                    });
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            raw_last_reg    <= 1'b1;
            stable_reg      <= 1'b1;
            last_change_reg <= '0;
            sound_en_reg    <= 1'b1;
            m_valid_reg     <= 1'b0;
            normal_lim_reg  <= TEMP_W'(RST_TEMP_NORMAL);
            atten_lim_reg   <= TEMP_W'(RST_TEMP_ATTENTION);
            crit_lim_reg    <= TEMP_W'(RST_TEMP_CRITICAL);
            dark_lim_reg    <= ADC_W'(RST_LDR_DARK);
            clear_lim_reg   <= ADC_W'(RST_LDR_CLEAR);
            pullup_reg      <= 1'b0;
            debounce_reg    <= DEB_W'(RST_DEBOUNCE);
        end else begin
            state_reg       <= state_next;
            raw_last_reg    <= raw_last_next;
            stable_reg      <= stable_next;
            last_change_reg <= last_change_next;
            sound_en_reg    <= sound_en_next;
            m_valid_reg     <= m_valid_next;
            // Configuration write transaction.
            if (cfg_valid) begin
                case (cfg_index)
                    REG_TEMP_NORMAL:    normal_lim_reg <= cfg_data[TEMP_W-1:0];
                    REG_TEMP_ATTENTION: atten_lim_reg  <= cfg_data[TEMP_W-1:0];
                    REG_TEMP_CRITICAL:  crit_lim_reg   <= cfg_data[TEMP_W-1:0];
                    REG_LDR_DARK:       dark_lim_reg   <= cfg_data[ADC_W-1:0];
                    REG_LDR_CLEAR:      clear_lim_reg  <= cfg_data[ADC_W-1:0];
                    REG_LDR_PULLUP:     pullup_reg     <= cfg_data[0];
                    REG_DEBOUNCE:       debounce_reg   <= cfg_data[DEB_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        toggled_reg  <= toggled_next;
        temp_raw_reg <= temp_raw_next;
        light_reg    <= light_next;
        temp_reg     <= temp_next;
        tcls_reg     <= tcls_next;
        lcls_reg     <= lcls_next;
        duty_reg     <= duty_next;
        m_data_reg   <= m_data_next;
    end

endmodule

/* sv/thlam_div.sv */
// Restoring divider for the red ramp, one quotient bit per cycle.
module thlam_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  thlam_pkg::div_cmd_t  cmd,
    output thlam_pkg::div_stat_t stat
);
    import thlam_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              fits;

    // One compare and subtract against the shifted divisor per step.
    always_comb begin
        fits      = rem_reg >= dsh_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_STEPS - 1);
            rem_next  = cmd.num;
            dsh_next  = NUM_W'({cmd.den, (QUOT_W - 1)'(0)});
            quot_next = '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule
